// ----- hdl/lfns_pkg.sv -----
package lfns_pkg;

  localparam int LINE_LIMIT          = 64;
  localparam int LINE_CNT_W          = $clog2(LINE_LIMIT);
  localparam int MAX_FRACTION_DIGITS = 9;
  localparam int FRAC_CNT_W          = 4;
  localparam int WHOLE_W             = 32;
  localparam int FRAC_W              = 30;
  localparam int GAIN_W              = 24;
  localparam int BIAS_W              = 32;
  localparam int VALUE_W             = 32;
  localparam int CFG_IDX_W           = 1;
  localparam int CFG_DATA_W          = 32;

  localparam int JQ_DEPTH  = 2;
  localparam int JQ_PTR_W  = $clog2(JQ_DEPTH);
  localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);

  localparam int DIV_STEPS = 17;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 1'b0,
    REG_BIAS = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic       clear_line;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;
  } out_item_t;

  typedef struct packed {
    logic [WHOLE_W-1:0]    whole_part;
    logic [FRAC_W-1:0]     fraction_digits;
    logic [FRAC_CNT_W-1:0] fraction_count;
    logic                  is_negative;
    logic                  part_overflow;
  } job_t;

  function automatic logic [FRAC_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
    logic [FRAC_W-1:0] r;
    case (n)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/lfns_front.sv -----
module lfns_front
  import lfns_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  in_item_t item_i,
  input  logic     accept_i,
  output job_t     job_o,
  output logic     job_push_o
);

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_WHOLE  = 2'd1,
    PH_FRAC   = 2'd2,
    PH_DONE   = 2'd3
  } scan_phase_e;

  scan_phase_e           phase_q, phase_d;
  logic [LINE_CNT_W-1:0] count_q, count_d;
  logic                  minus_q, minus_d;
  logic                  neg_q, neg_d;
  logic [WHOLE_W-1:0]    whole_q, whole_d;
  logic [FRAC_W-1:0]     frac_q, frac_d;
  logic [FRAC_CNT_W-1:0] fcnt_q, fcnt_d;
  logic                  ovf_q, ovf_d;

  logic [7:0]         b;
  logic               is_digit;
  logic [3:0]         dval;
  logic [WHOLE_W+3:0] wext, wnext;
  logic [FRAC_W-1:0]  fnext;

  assign b        = item_i.data_byte;
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
  assign dval     = 4'(b - CH_ZERO);
  assign wext     = {4'b0, whole_q};
  assign wnext    = (wext << 3) + (wext << 1) + {{WHOLE_W{1'b0}}, dval};
  assign fnext    = (frac_q << 3) + (frac_q << 1) + {{(FRAC_W-4){1'b0}}, dval};

  assign job_o.whole_part      = whole_q;
  assign job_o.fraction_digits = frac_q;
  assign job_o.fraction_count  = fcnt_q;
  assign job_o.is_negative     = neg_q;
  assign job_o.part_overflow   = ovf_q;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    minus_d    = minus_q;
    neg_d      = neg_q;
    whole_d    = whole_q;
    frac_d     = frac_q;
    fcnt_d     = fcnt_q;
    ovf_d      = ovf_q;
    job_push_o = 1'b0;
    if (accept_i) begin
      if (item_i.clear_line || b == CH_CR || b == CH_LF ||
          count_q == LINE_CNT_W'(LINE_LIMIT - 1)) begin
        if (!item_i.clear_line && (b == CH_CR || b == CH_LF) &&
            count_q != '0 && phase_q != PH_SEARCH) begin
          job_push_o = 1'b1;
        end
        phase_d = PH_SEARCH;
        count_d = '0;
        minus_d = 1'b0;
        neg_d   = 1'b0;
        whole_d = '0;
        frac_d  = '0;
        fcnt_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        count_d = count_q + 1'b1;
        unique case (phase_q)
          PH_SEARCH: begin
            if (is_digit) begin
              neg_d   = minus_q;
              phase_d = PH_WHOLE;
              whole_d = {{(WHOLE_W-4){1'b0}}, dval};
              minus_d = 1'b0;
            end else begin
              minus_d = (b == CH_MINUS);
            end
          end
          PH_WHOLE: begin
            if (is_digit) begin
              if (wnext[WHOLE_W+3:WHOLE_W] != 4'b0) begin
                whole_d = '1;
                ovf_d   = 1'b1;
              end else begin
                whole_d = wnext[WHOLE_W-1:0];
              end
            end else if (b == CH_DOT) begin
              phase_d = PH_FRAC;
            end else begin
              phase_d = PH_DONE;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (fcnt_q < FRAC_CNT_W'(MAX_FRACTION_DIGITS)) begin
                frac_d = fnext;
                fcnt_d = fcnt_q + 1'b1;
              end
            end else begin
              phase_d = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      count_q <= '0;
      minus_q <= 1'b0;
      neg_q   <= 1'b0;
      whole_q <= '0;
      frac_q  <= '0;
      fcnt_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
      minus_q <= minus_d;
      neg_q   <= neg_d;
      whole_q <= whole_d;
      frac_q  <= frac_d;
      fcnt_q  <= fcnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

// ----- hdl/lfns_job_queue.sv -----
module lfns_job_queue
  import lfns_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  job_t wr_data_i,
  input  logic wr_i,
  output logic full_o,
  output job_t rd_data_o,
  output logic empty_o,
  input  logic rd_i
);

  job_t                mem_q [JQ_DEPTH];
  logic [JQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JQ_CNT_W-1:0] cnt_q;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == JQ_CNT_W'(JQ_DEPTH));
  assign empty_o   = (cnt_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == JQ_PTR_W'(JQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/lfns_back.sv -----
module lfns_back
  import lfns_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  job_t                     job_i,
  input  logic                     job_empty_i,
  output logic                     job_pop_o,
  input  logic        [GAIN_W-1:0] gain_i,
  input  logic        [BIAS_W-1:0] bias_i,
  output out_item_t                out_o,
  output logic                     out_valid_o,
  input  logic                     pop_i
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_DIV  = 3'd1,
    ST_MUL  = 3'd2,
    ST_SUM  = 3'd3,
    ST_FIN  = 3'd4
  } back_state_e;

  back_state_e          state_q;
  logic [DIV_CNT_W-1:0] step_q;
  logic [30:0]          rem_q;
  logic [30:0]          dvs_q;
  logic [16:0]          nlow_q;
  logic [16:0]          quo_q;
  logic [WHOLE_W-1:0]   whole_q;
  logic                 neg_q;
  logic                 ovf_q;
  logic [48:0]          phi_q;
  logic [47:0]          plo_q;
  logic [57:0]          mag_q;
  logic                 out_valid_q;
  out_item_t            out_q;

  logic [FRAC_W-1:0]  p10;
  logic [46:0]        num;
  logic [31:0]        trial;
  logic               take;
  logic [48:0]        raw;
  logic               gneg;
  logic [GAIN_W-1:0]  gmag;
  logic [48:0]        lo_rnd;
  logic [59:0]        bias_ext;
  logic signed [59:0] sum;
  logic               out_free;

  assign p10      = pow10(job_i.fraction_count);
  assign num      = {job_i.fraction_digits, 17'b0} + {17'b0, p10};
  assign trial    = {rem_q, nlow_q[16]};
  assign take     = (trial >= {1'b0, dvs_q});
  assign raw      = {1'b0, whole_q, 16'b0} + {32'b0, quo_q};
  assign gneg     = gain_i[GAIN_W-1];
  assign gmag     = gneg ? (~gain_i + 1'b1) : gain_i;
  assign lo_rnd   = {1'b0, plo_q} + 49'd32768;
  assign bias_ext = {{28{bias_i[BIAS_W-1]}}, bias_i};
  assign sum      = (neg_q != gneg) ? signed'(bias_ext - {2'b0, mag_q})
                                    : signed'(bias_ext + {2'b0, mag_q});
  assign out_free = !out_valid_q || pop_i;

  assign job_pop_o   = (state_q == ST_IDLE) && !job_empty_i;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_i && !((state_q == ST_FIN) && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (!job_empty_i) begin
            state_q <= ST_DIV;
            step_q  <= '0;
          end
        end
        ST_DIV: begin
          if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_q <= ST_MUL;
          end
          step_q <= step_q + 1'b1;
        end
        ST_MUL: state_q <= ST_SUM;
        ST_SUM: state_q <= ST_FIN;
        ST_FIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        rem_q   <= num[46:17] + 31'd0;
        nlow_q  <= num[16:0];
        dvs_q   <= {p10, 1'b0};
        quo_q   <= '0;
        whole_q <= job_i.whole_part;
        neg_q   <= job_i.is_negative;
        ovf_q   <= job_i.part_overflow;
      end
      ST_DIV: begin
        rem_q  <= take ? 31'(trial - {1'b0, dvs_q}) : trial[30:0];
        nlow_q <= {nlow_q[15:0], 1'b0};
        quo_q  <= {quo_q[15:0], take};
      end
      ST_MUL: begin
        phi_q <= raw[48:24] * gmag;
        plo_q <= raw[23:0] * gmag;
      end
      ST_SUM: begin
        mag_q <= {1'b0, phi_q, 8'b0} + {25'b0, lo_rnd[48:16]};
      end
      ST_FIN: begin
        if (out_free) begin
          if (sum > 60'sd2147483647) begin
            out_q.value     <= 32'sh7fffffff;
            out_q.saturated <= 1'b1;
          end else if (sum < -60'sd2147483648) begin
            out_q.value     <= 32'sh80000000;
            out_q.saturated <= 1'b1;
          end else begin
            out_q.value     <= sum[VALUE_W-1:0];
            out_q.saturated <= ovf_q;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- hdl/line_first_number_scaler_top.sv -----
// Bytes are taken one per cycle while full is low; ordinary bytes finish in the cycle they
// arrive. A CR or LF that closes a line holding a number hands that number to a two-entry
// job queue, and the arithmetic unit turns it into a result in these steps: one load,
// 17 steps of a bit-serial divider for the fraction, one multiply, one add and a last step for
// bias and clamping. Full rises only while both queue entries wait, so line ends coming faster
// than the unit drains them stall the input. A result sits in an output register until popped.
module line_first_number_scaler_top
  import lfns_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  in_item_t              in_item_i,
  output logic                  empty,
  input  logic                  pop,
  output out_item_t             out_item_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic [GAIN_W-1:0] gain_q;
  logic [BIAS_W-1:0] bias_q;
  logic              accept;
  job_t              fr_job;
  logic              fr_push;
  logic              jq_full;
  job_t              jq_data;
  logic              jq_empty;
  logic              jq_pop;
  logic              out_valid;

  assign accept = push && !jq_full;
  assign full   = jq_full;
  assign empty  = !out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_W'(65536);
      bias_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GAIN: gain_q <= cfg_wdata_i[GAIN_W-1:0];
        REG_BIAS: bias_q <= cfg_wdata_i[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  lfns_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (in_item_i),
    .accept_i   (accept),
    .job_o      (fr_job),
    .job_push_o (fr_push)
  );

  lfns_job_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_data_i (fr_job),
    .wr_i      (fr_push),
    .full_o    (jq_full),
    .rd_data_o (jq_data),
    .empty_o   (jq_empty),
    .rd_i      (jq_pop)
  );

  lfns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (jq_data),
    .job_empty_i (jq_empty),
    .job_pop_o   (jq_pop),
    .gain_i      (gain_q),
    .bias_i      (bias_q),
    .out_o       (out_item_o),
    .out_valid_o (out_valid),
    .pop_i       (pop && out_valid)
  );

endmodule
